/* rtl/rtcd_pkg.sv */
package rtcd_pkg;

   // Largest image row the line store holds.
   localparam int unsigned RTCD_MAX_WIDTH = 1024;

   // Field widths of the channels and registers.
   localparam int RTCD_PIX_W      = 8;
   localparam int RTCD_CX_W       = 10;
   localparam int RTCD_CY_W       = 12;
   localparam int RTCD_GATE_W     = 8;
   localparam int RTCD_IW_W       = 11;
   localparam int RTCD_IH_W       = 13;
   localparam int RTCD_CSR_IDX_W  = 2;
   localparam int RTCD_CSR_DATA_W = 13;

   // Neighborhood geometry.
   localparam int RTCD_LINES  = 6;
   localparam int RTCD_WIN    = 7;
   localparam int RTCD_RADIUS = 3;
   localparam int RTCD_RING   = 16;
   localparam int RTCD_SUM_W  = RTCD_PIX_W + $clog2(RTCD_RING);
   localparam int RTCD_MEAN_SHIFT = $clog2(RTCD_RING);
   localparam int RTCD_SWAP_W = $clog2(RTCD_RING + 1);
   localparam int RTCD_SWAPS_NEEDED = 4;
   // A center is tested when the new pixel's column is at least twice the
   // radius and that column plus this margin is at most the row width.
   localparam int RTCD_FAR_MARGIN = 2;

   localparam logic [RTCD_CY_W-1:0] RTCD_ROW_MAX = '1;

   // Depth of the queue between the window front end and the ring test.
   localparam int RTCD_QDEPTH = 4;

   // Register reset values.
   localparam logic [RTCD_GATE_W-1:0] RTCD_GATE_RST   = 8'd38;
   localparam logic [RTCD_IW_W-1:0]   RTCD_WIDTH_RST  = 11'd640;
   localparam logic [RTCD_IH_W-1:0]   RTCD_HEIGHT_RST = 13'd480;

   typedef enum logic [RTCD_CSR_IDX_W-1:0] {
      CSR_GATE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } rtcd_csr_type;

   typedef struct packed {
      logic [RTCD_GATE_W-1:0] gate;
      logic [RTCD_IW_W-1:0]   width;
      logic [RTCD_IH_W-1:0]   height;
   } rtcd_cfg_type;

   // One classified center on its way from the window to the ring test.
   typedef struct packed {
      logic                                  tested;
      logic [RTCD_CX_W-1:0]                  center_x;
      logic [RTCD_CY_W-1:0]                  center_y;
      logic [RTCD_PIX_W-1:0]                 center;
      logic [RTCD_RING-1:0][RTCD_PIX_W-1:0]  ring;
   } rtcd_entry_type;

   // Ring offsets, counterclockwise from the point straight below the center.
   function automatic int ring_dx(input int i);
      int d;
      case (i)
         1, 7:          d = 1;
         2, 6:          d = 2;
         3, 4, 5:       d = 3;
         9, 15:         d = -1;
         10, 14:        d = -2;
         11, 12, 13:    d = -3;
         default:       d = 0;
      endcase
      return d;
   endfunction

   function automatic int ring_dy(input int i);
      int d;
      case (i)
         0, 1, 15:      d = 3;
         2, 14:         d = 2;
         3, 13:         d = 1;
         5, 11:         d = -1;
         6, 10:         d = -2;
         7, 8, 9:       d = -3;
         default:       d = 0;
      endcase
      return d;
   endfunction

endpackage

/* rtl/rtcd_if.sv */
interface rtcd_req_if import rtcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [RTCD_PIX_W-1:0] pixel;
   logic                  frame_start;

   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface rtcd_rsp_if import rtcd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 tested;
   logic                 is_corner;
   logic [RTCD_CX_W-1:0] center_x;
   logic [RTCD_CY_W-1:0] center_y;

   modport source (output valid, tested, is_corner, center_x, center_y, input ready);
   modport sink   (input valid, tested, is_corner, center_x, center_y, output ready);
endinterface

interface rtcd_csr_if import rtcd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [RTCD_CSR_IDX_W-1:0]  index;
   logic [RTCD_CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rtcd_ram.sv */
module rtcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rtcd_front.sv */
module rtcd_front import rtcd_pkg::*; #(
   parameter int unsigned MAX_WIDTH = RTCD_MAX_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   rtcd_req_if.sink       req_if,
   input  rtcd_cfg_type   cfg,
   input  logic           q_full,
   output logic           q_push,
   output rtcd_entry_type q_entry
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CMP_W  = (COL_W + 1 > RTCD_IW_W) ? COL_W + 1 : RTCD_IW_W;
   localparam int LINE_W = RTCD_LINES * RTCD_PIX_W;
   localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);
   localparam int EDGE = 2 * RTCD_RADIUS;

   logic [COL_W-1:0]     col_ff, col_in;
   logic [RTCD_CY_W-1:0] row_ff, row_in;

   logic                  a_valid_ff, a_valid_in;
   logic                  a_byp_ff, a_byp_in;
   logic [RTCD_PIX_W-1:0] a_pixel_ff;
   logic [COL_W-1:0]      a_col_ff;
   logic                  a_tested_ff;
   logic [RTCD_CX_W-1:0]  a_cx_ff;
   logic [RTCD_CY_W-1:0]  a_cy_ff;
   logic [LINE_W-1:0]     byp_data_ff;

   logic [RTCD_PIX_W-1:0] win_ff  [RTCD_WIN][RTCD_WIN];
   logic [RTCD_PIX_W-1:0] new_win [RTCD_WIN][RTCD_WIN];
   logic [RTCD_PIX_W-1:0] column  [RTCD_WIN];

   logic                 acc, a_adv, wrap, tested;
   logic [COL_W-1:0]     cur_col;
   logic [RTCD_CY_W-1:0] cur_row;
   logic [CMP_W-1:0]     width_ext, width_eff, col_ext;
   logic [RTCD_IH_W-1:0] row_ext;
   logic [CMP_W-1:0]     cx_full;
   logic [LINE_W-1:0]    ram_rdata, lines, wdata;

   assign acc          = req_if.valid && req_if.ready;
   assign a_adv        = a_valid_ff && !q_full;
   assign req_if.ready = !a_valid_ff || a_adv;

   always_comb begin
      cur_col   = req_if.frame_start ? '0 : col_ff;
      cur_row   = req_if.frame_start ? '0 : row_ff;
      width_ext = CMP_W'(cfg.width);
      width_eff = (width_ext > MAX_W_CMP) ? MAX_W_CMP : width_ext;
      col_ext   = CMP_W'(cur_col);
      row_ext   = RTCD_IH_W'(cur_row);
      tested    = (col_ext >= CMP_W'(EDGE)) && (row_ext >= RTCD_IH_W'(EDGE)) &&
                  (col_ext + CMP_W'(RTCD_FAR_MARGIN) <= width_eff) &&
                  (row_ext + RTCD_IH_W'(RTCD_FAR_MARGIN) <= cfg.height);
      cx_full   = col_ext - CMP_W'(RTCD_RADIUS);
      wrap      = (col_ext + CMP_W'(1) >= width_eff);

      col_in     = col_ff;
      row_in     = row_ff;
      a_valid_in = a_valid_ff;
      if (a_adv) begin
         a_valid_in = 1'b0;
      end
      a_byp_in = a_byp_ff;
      if (acc) begin
         a_valid_in = 1'b1;
         a_byp_in   = a_adv && (cur_col == a_col_ff);
         if (wrap) begin
            col_in = '0;
            row_in = (cur_row < RTCD_ROW_MAX) ? cur_row + RTCD_CY_W'(1) : cur_row;
         end else begin
            col_in = cur_col + COL_W'(1);
            row_in = cur_row;
         end
      end
   end

   // Line data for the stage-A item: the RAM output, or the data written in the
   // very cycle this column was read.
   always_comb begin
      lines = a_byp_ff ? byp_data_ff : ram_rdata;
      wdata = {a_pixel_ff, lines[LINE_W-1:RTCD_PIX_W]};
      for (int k = 0; k < RTCD_LINES; k++) begin
         column[k] = lines[k*RTCD_PIX_W +: RTCD_PIX_W];
      end
      column[RTCD_LINES] = a_pixel_ff;
      for (int r = 0; r < RTCD_WIN; r++) begin
         for (int c = 0; c < RTCD_WIN - 1; c++) begin
            new_win[r][c] = win_ff[r][c+1];
         end
         new_win[r][RTCD_WIN-1] = column[r];
      end
   end

   always_comb begin
      q_push            = a_adv;
      q_entry.tested    = a_tested_ff;
      q_entry.center_x  = a_cx_ff;
      q_entry.center_y  = a_cy_ff;
      q_entry.center    = new_win[RTCD_RADIUS][RTCD_RADIUS];
      for (int i = 0; i < RTCD_RING; i++) begin
         q_entry.ring[i] = new_win[RTCD_RADIUS + ring_dy(i)][RTCD_RADIUS + ring_dx(i)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         a_byp_ff   <= 1'b0;
         for (int r = 0; r < RTCD_WIN; r++) begin
            for (int c = 0; c < RTCD_WIN; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
         a_byp_ff   <= a_byp_in;
         if (a_adv) begin
            for (int r = 0; r < RTCD_WIN; r++) begin
               for (int c = 0; c < RTCD_WIN; c++) begin
                  win_ff[r][c] <= new_win[r][c];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         a_pixel_ff  <= req_if.pixel;
         a_col_ff    <= cur_col;
         a_tested_ff <= tested;
         a_cx_ff     <= tested ? cx_full[RTCD_CX_W-1:0] : '0;
         a_cy_ff     <= tested ? cur_row - RTCD_CY_W'(RTCD_RADIUS) : '0;
         byp_data_ff <= wdata;
      end
   end

   rtcd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data (wdata),
      .rd_en   (acc),
      .rd_addr (cur_col),
      .rd_data (ram_rdata)
   );

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(col_ff) < MAX_W_CMP)
      else $error("column counter beyond the line store");

endmodule

/* rtl/rtcd_queue.sv */
module rtcd_queue import rtcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rtcd_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output rtcd_entry_type pop_entry
);

   localparam int PTR_W = $clog2(RTCD_QDEPTH);
   localparam int CNT_W = $clog2(RTCD_QDEPTH + 1);

   rtcd_entry_type   entries_ff [RTCD_QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(RTCD_QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RTCD_QDEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RTCD_QDEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RTCD_QDEPTH))
      else $error("queue count exceeds depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

/* rtl/rtcd_back.sv */
module rtcd_back import rtcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RTCD_GATE_W-1:0] gate,
   input  logic                   not_empty,
   input  rtcd_entry_type         head,
   output logic                   pop,
   rtcd_rsp_if.source             rsp_if
);

   localparam int HALF = RTCD_RING / 2;
   localparam int HI_W = RTCD_PIX_W + 1;
   localparam int LO_W = RTCD_PIX_W + 2;

   // Stage 1: ring sum.
   logic                  s1_valid_ff, s1_valid_in;
   rtcd_entry_type        s1_entry_ff;
   logic [RTCD_SUM_W-1:0] s1_sum_ff, sum_c;

   // Stage 2: threshold flags for every ring point.
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_tested_ff, s2_cok_ff, s2_start_ff;
   logic [RTCD_CX_W-1:0] s2_cx_ff;
   logic [RTCD_CY_W-1:0] s2_cy_ff;
   logic [RTCD_RING-1:0] s2_below_ff, s2_above_ff;

   // Stage 3: hysteresis over the first half of the ring.
   logic                   s3_valid_ff, s3_valid_in;
   logic                   s3_tested_ff, s3_cok_ff, s3_high_ff;
   logic [RTCD_CX_W-1:0]   s3_cx_ff;
   logic [RTCD_CY_W-1:0]   s3_cy_ff;
   logic [HALF-1:0]        s3_below_ff, s3_above_ff;
   logic [RTCD_SWAP_W-1:0] s3_swaps_ff;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_tested_ff, rsp_corner_ff;
   logic [RTCD_CX_W-1:0] rsp_cx_ff;
   logic [RTCD_CY_W-1:0] rsp_cy_ff;

   logic s1_load, s2_load, s3_load, rsp_load;

   logic [RTCD_PIX_W-1:0]  mean;
   logic [HI_W-1:0]        hi;
   logic signed [LO_W-1:0] lo;
   logic [RTCD_RING-1:0]   below_c, above_c;
   logic                   cok_c, start_c;
   logic                   h1, h2;
   logic [RTCD_SWAP_W-1:0] sw1, sw2;

   assign rsp_load = s3_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign s3_load  = s2_valid_ff && (!s3_valid_ff || rsp_load);
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || s3_load);
   assign s1_load  = not_empty && (!s1_valid_ff || s2_load);
   assign pop      = s1_load;

   always_comb begin
      s1_valid_in  = s1_load ? 1'b1 : (s2_load  ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s2_load ? 1'b1 : (s3_load  ? 1'b0 : s2_valid_ff);
      s3_valid_in  = s3_load ? 1'b1 : (rsp_load ? 1'b0 : s3_valid_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      sum_c = '0;
      for (int i = 0; i < RTCD_RING; i++) begin
         sum_c = sum_c + RTCD_SUM_W'(head.ring[i]);
      end
   end

   // Thresholds sit one gate above and below the ring mean; the low one may go
   // negative, so it is compared as a signed value.
   always_comb begin
      mean = s1_sum_ff[RTCD_SUM_W-1:RTCD_MEAN_SHIFT];
      hi   = HI_W'(mean) + HI_W'(gate);
      lo   = $signed(LO_W'(mean)) - $signed(LO_W'(gate));
      for (int i = 0; i < RTCD_RING; i++) begin
         below_c[i] = $signed(LO_W'(s1_entry_ff.ring[i])) < lo;
         above_c[i] = HI_W'(s1_entry_ff.ring[i]) > hi;
      end
      cok_c   = ($signed(LO_W'(s1_entry_ff.center)) > lo) &&
                (HI_W'(s1_entry_ff.center) < hi);
      start_c = s1_entry_ff.ring[RTCD_RING-1] > mean;
   end

   always_comb begin
      h1  = s2_start_ff;
      sw1 = '0;
      for (int i = 0; i < HALF; i++) begin
         if (h1) begin
            if (s2_below_ff[i]) begin
               h1  = 1'b0;
               sw1 = sw1 + RTCD_SWAP_W'(1);
            end
         end else if (s2_above_ff[i]) begin
            h1  = 1'b1;
            sw1 = sw1 + RTCD_SWAP_W'(1);
         end
      end
      h2  = s3_high_ff;
      sw2 = s3_swaps_ff;
      for (int i = 0; i < HALF; i++) begin
         if (h2) begin
            if (s3_below_ff[i]) begin
               h2  = 1'b0;
               sw2 = sw2 + RTCD_SWAP_W'(1);
            end
         end else if (s3_above_ff[i]) begin
            h2  = 1'b1;
            sw2 = sw2 + RTCD_SWAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_entry_ff <= head;
         s1_sum_ff   <= sum_c;
      end
      if (s2_load) begin
         s2_tested_ff <= s1_entry_ff.tested;
         s2_cx_ff     <= s1_entry_ff.center_x;
         s2_cy_ff     <= s1_entry_ff.center_y;
         s2_below_ff  <= below_c;
         s2_above_ff  <= above_c;
         s2_cok_ff    <= cok_c;
         s2_start_ff  <= start_c;
      end
      if (s3_load) begin
         s3_tested_ff <= s2_tested_ff;
         s3_cx_ff     <= s2_cx_ff;
         s3_cy_ff     <= s2_cy_ff;
         s3_cok_ff    <= s2_cok_ff;
         s3_below_ff  <= s2_below_ff[RTCD_RING-1:HALF];
         s3_above_ff  <= s2_above_ff[RTCD_RING-1:HALF];
         s3_high_ff   <= h1;
         s3_swaps_ff  <= sw1;
      end
      if (rsp_load) begin
         rsp_tested_ff <= s3_tested_ff;
         rsp_corner_ff <= s3_tested_ff && s3_cok_ff &&
                          (sw2 == RTCD_SWAP_W'(RTCD_SWAPS_NEEDED));
         rsp_cx_ff     <= s3_cx_ff;
         rsp_cy_ff     <= s3_cy_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.tested    = rsp_tested_ff;
   assign rsp_if.is_corner = rsp_corner_ff;
   assign rsp_if.center_x  = rsp_cx_ff;
   assign rsp_if.center_y  = rsp_cy_ff;

   a_corner_tested: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_corner_ff) |-> rsp_tested_ff)
      else $error("corner flagged on an untested center");

   a_untested_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tested_ff) |-> (rsp_cx_ff == '0 && rsp_cy_ff == '0))
      else $error("untested result carries coordinates");

endmodule

/* rtl/ring_transition_corner_detect.sv */
// Streaming ring corner detector. Greyscale pixels arrive in raster order on
// the req channel, one transfer per pixel, with frame_start marking the first
// pixel of a frame; every pixel yields exactly one transfer on the rsp channel
// describing the center three rows up and three columns back. A tested center
// (column 3..width-5, row 3..height-5) is a corner when it lies strictly inside
// mean +/- gate_threshold of its 16-point radius-3 ring and the ring shows
// exactly four hysteresis transitions; untested results carry zeros. The block
// sustains one pixel per clock unless the queue is full: the six line stores
// form one 48-bit wide RAM of MAX_WIDTH words with one read and one write
// port, so each pixel costs one read and one write of that RAM, and a read of
// a column being written is forwarded. A four-entry queue separates the window
// front end from the four-stage ring test, so a stalled rsp side does not stop
// req until the queue and pipeline are full. The line store is not cleared
// after reset; it is filled by the first rows of a frame before any center
// uses it. The user must write registers (csr index: 0 gate_threshold, 1
// image_width, 2 image_height) only while the block is idle; the block does
// not enforce this. Writes to other indexes are ignored.
module ring_transition_corner_detect import rtcd_pkg::*; #(
   parameter int unsigned MAX_WIDTH = RTCD_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   rtcd_req_if.sink    req_if,
   rtcd_rsp_if.source  rsp_if,
   rtcd_csr_if.sink    csr_if
);

   // Configuration registers.
   logic [RTCD_GATE_W-1:0] gate_ff;
   logic [RTCD_IW_W-1:0]   width_ff;
   logic [RTCD_IH_W-1:0]   height_ff;
   rtcd_cfg_type           cfg;

   // Queue between the front end and the ring test.
   logic           q_push, q_full, q_pop, q_not_empty;
   rtcd_entry_type q_push_entry, q_head;

   // The register port never stalls; a write completes on every valid cycle.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff   <= RTCD_GATE_RST;
         width_ff  <= RTCD_WIDTH_RST;
         height_ff <= RTCD_HEIGHT_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (rtcd_csr_type'(csr_if.index))
            CSR_GATE:   gate_ff   <= csr_if.data[RTCD_GATE_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_if.data[RTCD_IW_W-1:0];
            CSR_HEIGHT: height_ff <= csr_if.data[RTCD_IH_W-1:0];
            default: begin
               // Unknown index: the write is dropped.
            end
         endcase
      end
   end

   always_comb begin
      cfg.gate   = gate_ff;
      cfg.width  = width_ff;
      cfg.height = height_ff;
   end

   // Front end: row and column tracking, line store, 7x7 window and the
   // interior check. It emits one classified entry per accepted pixel.
   rtcd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .cfg     (cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   rtcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (q_head)
   );

   // Back end: ring sum, thresholds, transition count and the result
   // register that drives rsp.
   rtcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .gate      (cfg.gate),
      .not_empty (q_not_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule
